// ----- design/sitdt_pkg.sv -----
// shared types, constants and the double-dabble step for the decimal text formatter
`timescale 1ns / 1ps

package sitdt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIGITS     = 10;
  localparam int BCD_BITS   = 4 * DIGITS;
  localparam int CONV_BITS  = BCD_BITS + VALUE_BITS;
  localparam int CFG_BITS   = 4;

  localparam logic [3:0] MAX_CHARS = 4'd11;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic REG_MIN_WIDTH = 1'b0;
  localparam logic REG_ZERO_FILL = 1'b1;

  // word moving through the binary to bcd stages
  typedef struct packed {
    logic                  neg;
    logic [BCD_BITS-1:0]   bcd;
    logic [VALUE_BITS-1:0] bin;
    logic [15:0]           start;
  } conv_t;

  // word handed to the serializer
  typedef struct packed {
    logic                neg;
    logic                fill_zero;
    logic [3:0]          ndig;
    logic [3:0]          nfill;
    logic [3:0]          total;
    logic [BCD_BITS-1:0] bcd;
    logic [15:0]         start;
  } text_t;

  // one shift-add-3 step over the bcd digits and the remaining binary bits
  function automatic logic [CONV_BITS-1:0] dabble(input logic [CONV_BITS-1:0] s);
    logic [CONV_BITS-1:0] t;
    t = s;
    for (int i = 0; i < DIGITS; i++) begin
      if (t[VALUE_BITS + 4*i +: 4] >= 4'd5) begin
        t[VALUE_BITS + 4*i +: 4] = t[VALUE_BITS + 4*i +: 4] + 4'd3;
      end
    end
    return {t[CONV_BITS-2:0], 1'b0};
  endfunction

endpackage

// ----- design/signed_int_to_decimal_text.sv -----
// top level of the signed integer to decimal ascii text formatter
`timescale 1ns / 1ps

// Formats a signed 32-bit value as decimal ascii, one character per output
// word, most significant first, with the buffer position of each character
// and a last flag on the final one. A negative value leads with '-', then
// fill characters (space, or '0' when zero_fill is set) pad the text to
// min_width total characters, sign included; min_width above 11 acts as 11.
// The most negative value prints as "-2147483648". Datapath: a sign and
// magnitude stage, four double-dabble stages of eight steps each, a stage
// that counts digits and fill, then a serializer. The serializer emits the
// characters of a word (1 to 11 of them) one per output word, and takes the
// next word as the last character of the current one is accepted; the
// pipeline ahead of the serializer keeps taking words while it drains.
// Configuration writes take effect at the next clock edge.

module signed_int_to_decimal_text import sitdt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,

  // configuration
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,

  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   value,
  input  logic [15:0]          start_position,

  // output words, one per character
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           ch,
  output logic [15:0]          position,
  output logic                 last
);

  localparam int CONV_STAGES = 4;
  localparam int STAGE_STEPS = VALUE_BITS / CONV_STAGES;

  // configuration registers
  logic [3:0] min_width;
  logic       zero_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= 4'd0;
      zero_fill <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_WIDTH: min_width <= cfg_data[3:0];
        REG_ZERO_FILL: zero_fill <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // sign and magnitude stage: magnitude taken as unsigned, so the most
  // negative value needs no special handling
  logic                  s0_valid;
  conv_t                 s0_data;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;

  assign neg_in = value[31];
  assign mag_in = neg_in ? (32'd0 - 32'(value)) : 32'(value);

  // chain of handshakes between stages
  logic  cv_valid [CONV_STAGES+1];
  logic  cv_ready [CONV_STAGES+1];
  conv_t cv_data  [CONV_STAGES+1];

  assign in_ready = !s0_valid || cv_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data.neg   <= neg_in;
      s0_data.bcd   <= '0;
      s0_data.bin   <= mag_in;
      s0_data.start <= start_position;
    end
  end

  assign cv_valid[0] = s0_valid;
  assign cv_data[0]  = s0_data;

  // binary to bcd, eight shift-add-3 steps per stage
  for (genvar g = 0; g < CONV_STAGES; g++) begin : g_conv
    sitdt_bcd_stage #(
      .STEPS (STAGE_STEPS)
    ) u_bcd (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cv_valid[g]),
      .up_ready (cv_ready[g]),
      .up_data  (cv_data[g]),
      .dn_valid (cv_valid[g+1]),
      .dn_ready (cv_ready[g+1]),
      .dn_data  (cv_data[g+1])
    );
  end

  // digit count, width clamp and fill length
  logic  fm_valid;
  logic  fm_ready;
  text_t fm_data;

  sitdt_format u_format (
    .clk       (clk),
    .rst       (rst),
    .min_width (min_width),
    .zero_fill (zero_fill),
    .up_valid  (cv_valid[CONV_STAGES]),
    .up_ready  (cv_ready[CONV_STAGES]),
    .up_data   (cv_data[CONV_STAGES]),
    .dn_valid  (fm_valid),
    .dn_ready  (fm_ready),
    .dn_data   (fm_data)
  );

  // one character per cycle to the output while out_ready is high
  sitdt_serializer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (fm_valid),
    .up_ready  (fm_ready),
    .up_data   (fm_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ch        (ch),
    .position  (position),
    .last      (last)
  );

endmodule

// ----- design/sitdt_bcd_stage.sv -----
// one registered stage of the pipelined binary to bcd conversion
`timescale 1ns / 1ps

module sitdt_bcd_stage import sitdt_pkg::*; #(
  parameter int STEPS = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  conv_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output conv_t dn_data
);

  conv_t                data_next;
  logic [CONV_BITS-1:0] s;

  always_comb begin
    s = {up_data.bcd, up_data.bin};
    for (int i = 0; i < STEPS; i++) begin
      s = dabble(s);
    end
    data_next       = up_data;
    data_next.bcd   = s[CONV_BITS-1:VALUE_BITS];
    data_next.bin   = s[VALUE_BITS-1:0];
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule

// ----- design/sitdt_format.sv -----
// digit count and fill length stage
`timescale 1ns / 1ps

module sitdt_format import sitdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] min_width,
  input  logic       zero_fill,
  input  logic       up_valid,
  output logic       up_ready,
  input  conv_t      up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output text_t      dn_data
);

  logic [3:0] ndig;
  logic [3:0] width;
  logic [3:0] body;
  logic [3:0] nfill;
  text_t      data_next;

  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < DIGITS; i++) begin
      if (up_data.bcd[4*i +: 4] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
    width = (min_width > MAX_CHARS) ? MAX_CHARS : min_width;
    body  = (up_data.neg && width != 4'd0) ? width - 4'd1 : width;
    nfill = (body > ndig) ? body - ndig : 4'd0;

    data_next.neg       = up_data.neg;
    data_next.fill_zero = zero_fill;
    data_next.ndig      = ndig;
    data_next.nfill     = nfill;
    data_next.total     = {3'b000, up_data.neg} + nfill + ndig;
    data_next.bcd       = up_data.bcd;
    data_next.start     = up_data.start;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule

// ----- design/sitdt_serializer.sv -----
// emits one character per cycle from a formatted word while the receiver is ready
`timescale 1ns / 1ps

module sitdt_serializer import sitdt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  text_t       up_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  ch,
  output logic [15:0] position,
  output logic        last
);

  localparam int PW = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  logic          busy;
  logic [3:0]    k;
  text_t         text;

  logic [3:0]    j;
  logic [3:0]    d;
  logic [3:0]    digit;
  logic [PW-1:0] pos_sum;

  always_comb begin
    j     = k - {3'b000, text.neg};
    d     = text.ndig - 4'd1 - (j - text.nfill);
    digit = (d < 4'(DIGITS)) ? text.bcd[4*d +: 4] : 4'd0;
    if (text.neg && k == 4'd0) begin
      ch = CHAR_MINUS;
    end else if (j < text.nfill) begin
      ch = text.fill_zero ? CHAR_ZERO : CHAR_SPACE;
    end else begin
      ch = CHAR_ZERO + {4'b0000, digit};
    end
  end

  assign pos_sum   = text.start[PW-1:0] + PW'(k);
  assign position  = 16'(pos_sum);
  assign last      = (k == text.total - 4'd1);
  assign out_valid = busy;
  assign up_ready  = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 4'd0;
    end else if (up_ready) begin
      busy <= up_valid;
      k    <= 4'd0;
    end else if (out_ready) begin
      k <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      text <= up_data;
    end
  end

endmodule

// ----- tb/tb_signed_int_to_decimal_text.sv -----
// testbench for the signed integer to decimal ascii text formatter
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_text;
  import sitdt_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_STALL      = 300;   // receiver hold-off, long enough to fill the pipeline
  localparam int DRAIN_CYCLES    = 30;
  localparam int WORDS_PER_PHASE = 16;
  localparam int BURST_WORDS     = 15;

  // pacing of the two channels
  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  // one expected character word
  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] position;
    logic        last;
  } char_word_t;

  // one row of the directed table; an empty text means the predictor decides
  typedef struct {
    logic signed [31:0] value;
    logic [15:0]        start;
    logic [3:0]         min_width;
    logic               zero_fill;
    string              text;
  } text_case_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_write      = 1'b0;
  logic                cfg_index      = REG_MIN_WIDTH;
  logic [CFG_BITS-1:0] cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic signed [31:0]  value          = '0;
  logic [15:0]         start_position = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [7:0]          ch;
  logic [15:0]         position;
  logic                last;

  // local copy of the two registers, as written
  logic [3:0] width_setting = 4'd0;
  logic       fill_setting  = 1'b0;

  // characters still owed by the block, oldest first
  char_word_t expected_chars [$];

  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  bit  stall_request      = 1'b0;
  int  error_count        = 0;
  int  cycle_count        = 0;
  int  words_sent         = 0;
  int  chars_checked      = 0;
  int  settings_used      = 0;
  int  input_stall_cycles = 0;

  // directed rows: extremes, sign and fill cases, width saturation, position wrap
  text_case_t directed_cases [20] = '{
    '{32'sd0,           16'd0,      4'd0,  1'b0, "0"},
    '{32'sd7,           16'd100,    4'd0,  1'b0, ""},
    '{-32'sd1,          16'd5,      4'd0,  1'b0, "-1"},
    '{32'sh7fff_ffff,   16'hffff,   4'd0,  1'b0, "2147483647"},
    '{32'sh8000_0000,   16'hfffa,   4'd0,  1'b0, "-2147483648"},
    '{32'sd1,           16'd0,      4'd0,  1'b0, "1"},
    '{32'sd42,          16'd0,      4'd5,  1'b0, "   42"},
    '{-32'sd42,         16'd0,      4'd5,  1'b0, "-  42"},
    '{32'sd42,          16'h8000,   4'd5,  1'b1, "00042"},
    '{-32'sd42,         16'd0,      4'd5,  1'b1, "-0042"},
    '{32'sd0,           16'd0,      4'd11, 1'b1, "00000000000"},
    '{-32'sd5,          16'd0,      4'd11, 1'b1, "-0000000005"},
    '{-32'sd1000000000, 16'd0,      4'd11, 1'b0, ""},
    '{32'sd5,           16'd0,      4'd15, 1'b0, "          5"},
    '{32'sh8000_0000,   16'd0,      4'd15, 1'b1, "-2147483648"},
    '{32'sd123456789,   16'd0,      4'd12, 1'b1, ""},
    '{-32'sd9,          16'd0,      4'd1,  1'b0, "-9"},
    '{32'sd9,           16'hffff,   4'd2,  1'b0, " 9"},
    '{32'sd1000000000,  16'd0,      4'd10, 1'b1, "1000000000"},
    '{-32'sd123,        16'd0,      4'd4,  1'b1, "-123"}
  };

  signed_int_to_decimal_text #(
    .POSITION_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .start_position(start_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ch(ch),
    .position(position),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // works out the characters one value gives under the current registers
  function automatic void predict_text(input logic signed [31:0] v, input logic [15:0] start);
    logic [31:0] magnitude;
    logic        negative;
    logic [7:0]  digits [10];
    logic [7:0]  chars [11];
    int          ndig;
    int          width;
    int          body;
    int          nfill;
    int          n;
    negative  = v[31];
    // unsigned negate, so the most negative value keeps its full magnitude
    magnitude = negative ? (32'd0 - 32'(v)) : 32'(v);
    ndig = 0;
    if (magnitude == 0) begin
      digits[0] = CHAR_ZERO;
      ndig = 1;
    end
    while (magnitude != 0) begin
      digits[ndig] = CHAR_ZERO + 8'(magnitude % 10);
      magnitude = magnitude / 10;
      ndig++;
    end
    // widths past eleven act as eleven; the sign eats one column of the width
    width = (width_setting > MAX_CHARS) ? int'(MAX_CHARS) : int'(width_setting);
    body  = (negative && width > 0) ? width - 1 : width;
    nfill = (body > ndig) ? body - ndig : 0;
    n = 0;
    if (negative) begin
      chars[n] = CHAR_MINUS;
      n++;
    end
    repeat (nfill) begin
      chars[n] = fill_setting ? CHAR_ZERO : CHAR_SPACE;
      n++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      chars[n] = digits[i];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      expected_chars.push_back('{chars[k], start + 16'(k), (k == n - 1)});
    end
  endfunction

  // queues a typed-in string as the expected characters
  function automatic void expect_text(input string s, input logic [15:0] start);
    for (int k = 0; k < s.len(); k++) begin
      expected_chars.push_back('{s[k], start + 16'(k), (k == s.len() - 1)});
    end
  endfunction

  function automatic void set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        sender_idle_pct    = 56;
        receiver_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 56;
      end
      default: begin
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
      end
    endcase
  endfunction

  // random value: full range, small numbers, powers of ten and the extremes
  function automatic logic signed [31:0] random_value();
    logic [31:0] ten;
    ten = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 999);
      2: return -$signed(32'($urandom_range(1, 999)));
      3: begin
        repeat ($urandom_range(0, 9)) ten = ten * 10;
        ten = ten - 32'($urandom_range(0, 1));
        return $urandom_range(0, 1) ? $signed(ten) : -$signed(ten);
      end
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'sd0;
          1: return -32'sd1;
          2: return 32'sh7fff_ffff;
          3: return 32'sh8000_0000;
          default: return 32'sh8000_0001;
        endcase
      end
      default: return $urandom() | 32'h8000_0000;
    endcase
  endfunction

  // start positions: anywhere, with some near the top so the position wraps
  function automatic logic [15:0] random_start();
    if ($urandom_range(0, 3) == 0) begin
      return 16'hfff0 + 16'($urandom_range(0, 15));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // offer one word, with random idle cycles ahead of it; valid stays up after
  // the accept so back-to-back words never drop it within one step
  task automatic send_word(input logic signed [31:0] v, input logic [15:0] start,
                           input string text);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid       <= 1'b1;
    value          <= v;
    start_position <= start;
    do @(posedge clk); while (!in_ready);
    if (text.len() == 0) begin
      predict_text(v, start);
    end else begin
      expect_text(text, start);
    end
    words_sent++;
  endtask

  // stop offering and wait until every owed character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // both registers, one per cycle; spare data bits of the fill write are random
  task automatic write_config(input logic [3:0] min_width, input logic zero_fill);
    cfg_write <= 1'b1;
    cfg_index <= REG_MIN_WIDTH;
    cfg_data  <= min_width;
    @(posedge clk);
    cfg_index <= REG_ZERO_FILL;
    cfg_data  <= {3'($urandom_range(0, 7)), zero_fill};
    @(posedge clk);
    cfg_write <= 1'b0;
    width_setting = min_width;
    fill_setting  = zero_fill;
    settings_used++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // compare every accepted character word with the oldest expectation
  always @(posedge clk) begin
    char_word_t want;
    if (!rst) begin
      if (in_valid && !in_ready) begin
        input_stall_cycles++;
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: ch %0h position %0h last %0b", ch, position, last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (ch !== want.ch) begin
            $error("ch: expected %0h, got %0h", want.ch, ch);
            error_count++;
          end
          if (position !== want.position) begin
            $error("position: expected %0h, got %0h", want.position, position);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [3:0] phase_width;
    logic       phase_fill;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; registers change only once the block has drained
    set_pace(PACE_FULL);
    foreach (directed_cases[i]) begin
      if (directed_cases[i].min_width != width_setting ||
          directed_cases[i].zero_fill != fill_setting) begin
        wait_drained();
        write_config(directed_cases[i].min_width, directed_cases[i].zero_fill);
      end
      send_word(directed_cases[i].value, directed_cases[i].start, directed_cases[i].text);
    end

    // random words, one pacing and one register setting per phase
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          phase_width = 4'd11;
          phase_fill  = 1'b1;
        end
        1: begin
          phase_width = 4'd0;
          phase_fill  = 1'b1;
        end
        2: begin
          phase_width = 4'd15;
          phase_fill  = 1'b0;
        end
        default: begin
          phase_width = 4'($urandom_range(0, 15));
          phase_fill  = 1'($urandom_range(0, 1));
        end
      endcase
      wait_drained();
      write_config(phase_width, phase_fill);
      set_pace(pace_t'(p));
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // long receiver hold-off while words keep coming, so the input backs up
        if (p == PACE_RECEIVER_STALL && i == 5) begin
          stall_request = 1'b1;
          repeat (BURST_WORDS) send_word(random_value(), random_start(), "");
        end
        // sender pauses until everything owed has come out
        if (p == PACE_SENDER_IDLE && i == 12) begin
          wait_drained();
        end
        send_word(random_value(), random_start(), "");
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words, %0d characters checked, %0d register settings",
             words_sent, chars_checked, settings_used);
    $display("input held back for %0d cycles by output backpressure", input_stall_cycles);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
